/* src/jcp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the joint constraint projection block.
// No dependencies.
package jcp_pkg;

	localparam int CoordW = 32;   // Q16.16 coordinates
	localparam int DiffW  = 33;   // exact difference of two coordinates
	localparam int MagW   = 33;   // magnitude of a difference
	localparam int SqW    = 66;   // square of a magnitude
	localparam int SumW   = 68;   // sum of three squares, padded to even width
	localparam int RootW  = 34;   // floor(sqrt(sum))
	localparam int RemW   = 36;   // square root partial remainder
	localparam int RestW  = 31;   // rest distance register
	localparam int IncrW  = 35;   // rest distance minus length
	localparam int MiW    = 34;   // magnitude of incr
	localparam int LoW    = 17;   // low slice of incr for the split multiply
	localparam int HiW    = MiW - LoW;
	localparam int PartW  = LoW + MagW;
	localparam int NumW   = MiW + MagW;   // dividend width
	localparam int QuoW   = 34;   // quotient width, bounded by |incr|
	localparam int ProdW  = 65;   // axis times hinge difference
	localparam int HingeW = 49;   // hinge term after the Q16 shift
	localparam int BaseW  = 50;   // exact pre-saturation sum
	localparam int FracW  = 16;
	localparam int Thresh = 3277; // 0.05 in Q16.16
	localparam int IdxW   = 3;
	localparam int Lanes  = 3;

	typedef enum logic [IdxW-1:0] {
		REG_JOINT_TYPE = 3'd0,
		REG_REST_DIST  = 3'd1,
		REG_OFFSET_X   = 3'd2,
		REG_OFFSET_Y   = 3'd3,
		REG_OFFSET_Z   = 3'd4,
		REG_AXIS_X     = 3'd5,
		REG_AXIS_Y     = 3'd6,
		REG_AXIS_Z     = 3'd7
	} jcp_reg_t;

	typedef enum logic [1:0] {
		JOINT_FIXED  = 2'd0,
		JOINT_HINGE  = 2'd1,
		JOINT_CIRC   = 2'd2,
		JOINT_UNUSED = 2'd3
	} jcp_joint_t;

	// Side data carried alongside the square root pipeline
	typedef struct packed {
		logic [Lanes-1:0][BaseW-1:0] base;
		logic [Lanes-1:0]            dneg;
		logic [Lanes-1:0][MagW-1:0]  mag;
		logic                        corr;
		logic                        zv;
	} jcp_side_t;

	// Side data carried alongside the divider pipeline
	typedef struct packed {
		logic [Lanes-1:0][BaseW-1:0] base;
		logic [Lanes-1:0]            neg;
		logic                        apply;
		logic                        zv;
	} jcp_dside_t;

endpackage

/* src/jcp_pos_if.sv */
`timescale 1ns / 1ps
// Input channel: positions of body A and body B.
// Depends on jcp_pkg.
interface jcp_pos_if;
	logic                                valid;
	logic                                ready;
	logic signed [jcp_pkg::CoordW-1:0]   a_x;
	logic signed [jcp_pkg::CoordW-1:0]   a_y;
	logic signed [jcp_pkg::CoordW-1:0]   a_z;
	logic signed [jcp_pkg::CoordW-1:0]   b_x;
	logic signed [jcp_pkg::CoordW-1:0]   b_y;
	logic signed [jcp_pkg::CoordW-1:0]   b_z;
	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

/* src/jcp_res_if.sv */
`timescale 1ns / 1ps
// Result channel: corrected body B position and flags.
// Depends on jcp_pkg.
interface jcp_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [jcp_pkg::CoordW-1:0]   new_b_x;
	logic signed [jcp_pkg::CoordW-1:0]   new_b_y;
	logic signed [jcp_pkg::CoordW-1:0]   new_b_z;
	logic                                zero_velocity;
	logic                                distance_corrected;
	modport source (output valid, new_b_x, new_b_y, new_b_z, zero_velocity,
		distance_corrected, input ready);
	modport sink (input valid, new_b_x, new_b_y, new_b_z, zero_velocity,
		distance_corrected, output ready);
endinterface

/* src/jcp_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on jcp_pkg.
interface jcp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [jcp_pkg::IdxW-1:0]      index;
	logic [jcp_pkg::CoordW-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/joint_constraint_projection.sv */
`timescale 1ns / 1ps
// Top level of the joint constraint projection block.
// Depends on jcp_pkg, the channel interfaces, jcp_sqrt and jcp_div.
//
// Takes one word of body A/B positions per cycle and returns one word with the
// corrected body B position, fully pipelined: a new word may enter every cycle
// unless the pipeline is stalled. Each word passes 3 front stages, a 34-stage
// square root, 3 stages for the correction magnitude, a 34-stage three-lane
// divider and the output register; the square root and the divider dominate
// that depth. One global stall: the whole pipeline freezes only while the
// output register holds a word that is not taken, so pos.ready is low exactly
// then. Config writes are always accepted (cfg.ready is tied high) and must be
// done with the pipeline empty. Fixed joint: B = A + offset, zero_velocity set.
// Hinge: B += trunc(axis * (A - B) / 2^16) per axis, then the distance fix.
// Circular: B moves along (B - A)/L by rest - L when |rest - L| > 0.05 and
// L != 0. All sums are exact and saturated once to signed 32 bits.
module joint_constraint_projection (
	input  logic     clk,
	input  logic     arst_n,
	jcp_pos_if.sink  pos,
	jcp_cfg_if.sink  cfg,
	jcp_res_if.source res
);
	localparam int L = jcp_pkg::Lanes;

	// ---------------- configuration registers ----------------
	jcp_pkg::jcp_joint_t                         jtype_q;
	logic [jcp_pkg::RestW-1:0]                   rest_q;
	logic [L-1:0][jcp_pkg::CoordW-1:0]           off_q;
	logic [L-1:0][jcp_pkg::CoordW-1:0]           axis_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jtype_q <= jcp_pkg::JOINT_CIRC;
			rest_q  <= jcp_pkg::RestW'(65536);
			off_q   <= '0;
			axis_q  <= {jcp_pkg::CoordW'(0), jcp_pkg::CoordW'(65536), jcp_pkg::CoordW'(0)};
		end else if (cfg.valid) begin
			case (jcp_pkg::jcp_reg_t'(cfg.index))
				jcp_pkg::REG_JOINT_TYPE: jtype_q   <= jcp_pkg::jcp_joint_t'(cfg.data[1:0]);
				jcp_pkg::REG_REST_DIST:  rest_q    <= cfg.data[jcp_pkg::RestW-1:0];
				jcp_pkg::REG_OFFSET_X:   off_q[0]  <= cfg.data;
				jcp_pkg::REG_OFFSET_Y:   off_q[1]  <= cfg.data;
				jcp_pkg::REG_OFFSET_Z:   off_q[2]  <= cfg.data;
				jcp_pkg::REG_AXIS_X:     axis_q[0] <= cfg.data;
				jcp_pkg::REG_AXIS_Y:     axis_q[1] <= cfg.data;
				jcp_pkg::REG_AXIS_Z:     axis_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------- global stall ----------------
	logic en;
	logic out_vld_q;
	assign en        = !out_vld_q || res.ready;
	assign pos.ready = en;

	// ---------------- stage 1: differences ----------------
	logic [L-1:0][jcp_pkg::CoordW-1:0] a_in, b_in;
	assign a_in = {pos.a_z, pos.a_y, pos.a_x};
	assign b_in = {pos.b_z, pos.b_y, pos.b_x};

	logic                               v_s1;
	logic [L-1:0][jcp_pkg::DiffW-1:0]   d_s1;    // B - A
	logic [L-1:0][jcp_pkg::DiffW-1:0]   hd_s1;   // A - B
	logic [L-1:0][jcp_pkg::DiffW-1:0]   fix_s1;  // A + offset
	logic [L-1:0][jcp_pkg::CoordW-1:0]  b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= pos.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < L; i++) begin
				d_s1[i]   <= jcp_pkg::DiffW'($signed(b_in[i]) - $signed(a_in[i]));
				hd_s1[i]  <= jcp_pkg::DiffW'($signed(a_in[i]) - $signed(b_in[i]));
				fix_s1[i] <= jcp_pkg::DiffW'($signed(a_in[i]) + $signed(off_q[i]));
				b_s1[i]   <= b_in[i];
			end
		end
	end

	// ---------------- stage 2: squares and hinge products ----------------
	logic [L-1:0][jcp_pkg::MagW-1:0] mag_c;
	logic [L-1:0]                    dneg_c;

	always_comb begin
		for (int i = 0; i < L; i++) begin
			dneg_c[i] = d_s1[i][jcp_pkg::DiffW-1];
			mag_c[i]  = dneg_c[i] ? jcp_pkg::MagW'(-d_s1[i]) : d_s1[i];
		end
	end

	logic                               v_s2;
	logic [L-1:0][jcp_pkg::SqW-1:0]     sq_s2;
	logic [L-1:0][jcp_pkg::ProdW-1:0]   hp_s2;
	logic [L-1:0][jcp_pkg::MagW-1:0]    mag_s2;
	logic [L-1:0]                       dneg_s2;
	logic [L-1:0][jcp_pkg::DiffW-1:0]   fix_s2;
	logic [L-1:0][jcp_pkg::CoordW-1:0]  b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < L; i++) begin
				sq_s2[i] <= jcp_pkg::SqW'({{(jcp_pkg::SqW-jcp_pkg::MagW){1'b0}}, mag_c[i]}
					* {{(jcp_pkg::SqW-jcp_pkg::MagW){1'b0}}, mag_c[i]});
				hp_s2[i] <= jcp_pkg::ProdW'($signed(axis_q[i]) * $signed(hd_s1[i]));
			end
			mag_s2  <= mag_c;
			dneg_s2 <= dneg_c;
			fix_s2  <= fix_s1;
			b_s2    <= b_s1;
		end
	end

	// ---------------- stage 3: sum of squares, base position ----------------
	logic [jcp_pkg::SumW-1:0] sum_c;
	jcp_pkg::jcp_side_t       side_c;

	always_comb begin
		logic signed [jcp_pkg::ProdW-1:0]  hp;
		logic signed [jcp_pkg::ProdW-1:0]  hr;
		logic signed [jcp_pkg::HingeW-1:0] ht;
		sum_c = jcp_pkg::SumW'(sq_s2[0]) + jcp_pkg::SumW'(sq_s2[1])
			+ jcp_pkg::SumW'(sq_s2[2]);
		side_c.dneg = dneg_s2;
		side_c.mag  = mag_s2;
		side_c.zv   = (jtype_q == jcp_pkg::JOINT_FIXED);
		side_c.corr = (jtype_q == jcp_pkg::JOINT_HINGE) || (jtype_q == jcp_pkg::JOINT_CIRC);
		for (int i = 0; i < L; i++) begin
			hp = $signed(hp_s2[i]);
			// truncate toward zero: bias negatives before the arithmetic shift
			hr = hp + (hp[jcp_pkg::ProdW-1] ? jcp_pkg::ProdW'(65535) : jcp_pkg::ProdW'(0));
			ht = jcp_pkg::HingeW'(hr >>> jcp_pkg::FracW);
			case (jtype_q)
				jcp_pkg::JOINT_FIXED:
					side_c.base[i] = jcp_pkg::BaseW'($signed(fix_s2[i]));
				jcp_pkg::JOINT_HINGE:
					side_c.base[i] = jcp_pkg::BaseW'($signed(b_s2[i]))
						+ jcp_pkg::BaseW'(ht);
				default:
					side_c.base[i] = jcp_pkg::BaseW'($signed(b_s2[i]));
			endcase
		end
	end

	logic                     v_s3;
	logic [jcp_pkg::SumW-1:0] sum_s3;
	jcp_pkg::jcp_side_t       side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sum_c;
			side_s3 <= side_c;
		end
	end

	// ---------------- length: pipelined square root ----------------
	logic                      sq_vld;
	logic [jcp_pkg::RootW-1:0] sq_root;
	jcp_pkg::jcp_side_t        sq_side;

	jcp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_rad    (sum_s3),
		.in_side   (side_s3),
		.out_valid (sq_vld),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// ---------------- stage 4: incr and threshold ----------------
	logic signed [jcp_pkg::IncrW-1:0] incr_c;
	logic                             apply_c;

	always_comb begin
		incr_c  = $signed({{(jcp_pkg::IncrW-jcp_pkg::RestW){1'b0}}, rest_q})
			- $signed({1'b0, sq_root});
		apply_c = sq_side.corr && (sq_root != '0)
			&& ((incr_c > jcp_pkg::IncrW'(jcp_pkg::Thresh))
			|| (incr_c < -jcp_pkg::IncrW'(jcp_pkg::Thresh)));
	end

	logic                              v_s4;
	logic [jcp_pkg::MiW-1:0]           mi_s4;
	logic [jcp_pkg::RootW-1:0]         len_s4;
	logic [L-1:0][jcp_pkg::MagW-1:0]   mag_s4;
	jcp_pkg::jcp_dside_t               ds_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= sq_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mi_s4        <= incr_c[jcp_pkg::IncrW-1] ? jcp_pkg::MiW'(-incr_c)
				: jcp_pkg::MiW'(incr_c);
			len_s4       <= sq_root;
			mag_s4       <= sq_side.mag;
			ds_s4.base   <= sq_side.base;
			ds_s4.neg    <= sq_side.dneg ^ {L{incr_c[jcp_pkg::IncrW-1]}};
			ds_s4.apply  <= apply_c;
			ds_s4.zv     <= sq_side.zv;
		end
	end

	// ---------------- stage 5: split products |incr| * |d| ----------------
	logic                              v_s5;
	logic [L-1:0][jcp_pkg::PartW-1:0]  plo_s5, phi_s5;
	logic [jcp_pkg::RootW-1:0]         len_s5;
	jcp_pkg::jcp_dside_t               ds_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < L; i++) begin
				plo_s5[i] <= jcp_pkg::PartW'(mi_s4[jcp_pkg::LoW-1:0])
					* jcp_pkg::PartW'(mag_s4[i]);
				phi_s5[i] <= jcp_pkg::PartW'(mi_s4[jcp_pkg::MiW-1:jcp_pkg::LoW])
					* jcp_pkg::PartW'(mag_s4[i]);
			end
			len_s5 <= len_s4;
			ds_s5  <= ds_s4;
		end
	end

	// ---------------- stage 6: dividend ----------------
	logic                              v_s6;
	logic [L-1:0][jcp_pkg::NumW-1:0]   num_s6;
	logic [jcp_pkg::RootW-1:0]         len_s6;
	jcp_pkg::jcp_dside_t               ds_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < L; i++) begin
				num_s6[i] <= {phi_s5[i], {jcp_pkg::LoW{1'b0}}}
					+ jcp_pkg::NumW'(plo_s5[i]);
			end
			len_s6 <= len_s5;
			ds_s6  <= ds_s5;
		end
	end

	// ---------------- correction magnitude: pipelined divider ----------------
	logic                              dv_vld;
	logic [L-1:0][jcp_pkg::QuoW-1:0]   dv_quo;
	jcp_pkg::jcp_dside_t               dv_side;

	jcp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_num    (num_s6),
		.in_den    (len_s6),
		.in_side   (ds_s6),
		.out_valid (dv_vld),
		.out_quo   (dv_quo),
		.out_side  (dv_side)
	);

	// ---------------- output: apply, saturate, register ----------------
	logic [L-1:0][jcp_pkg::CoordW-1:0] nb_c;

	always_comb begin
		logic signed [jcp_pkg::BaseW-1:0] term;
		logic signed [jcp_pkg::BaseW-1:0] tot;
		for (int i = 0; i < L; i++) begin
			term = $signed(jcp_pkg::BaseW'(dv_quo[i]));
			if (!dv_side.apply) term = '0;
			else if (dv_side.neg[i]) term = -term;
			tot = $signed(dv_side.base[i]) + term;
			if (tot > $signed(jcp_pkg::BaseW'(32'sh7FFF_FFFF)))
				nb_c[i] = 32'h7FFF_FFFF;
			else if (tot < -$signed(jcp_pkg::BaseW'(33'sh0_8000_0000)))
				nb_c[i] = 32'h8000_0000;
			else
				nb_c[i] = tot[jcp_pkg::CoordW-1:0];
		end
	end

	logic [L-1:0][jcp_pkg::CoordW-1:0] nb_q;
	logic                              zv_q;
	logic                              dc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nb_q <= nb_c;
			zv_q <= dv_side.zv;
			dc_q <= dv_side.apply;
		end
	end

	assign res.valid              = out_vld_q;
	assign res.new_b_x            = nb_q[0];
	assign res.new_b_y            = nb_q[1];
	assign res.new_b_z            = nb_q[2];
	assign res.zero_velocity      = zv_q;
	assign res.distance_corrected = dc_q;
endmodule

/* src/jcp_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on jcp_pkg.
module jcp_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [jcp_pkg::SumW-1:0]     in_rad,
	input  jcp_pkg::jcp_side_t           in_side,
	output logic                         out_valid,
	output logic [jcp_pkg::RootW-1:0]    out_root,
	output jcp_pkg::jcp_side_t           out_side
);
	localparam int N = jcp_pkg::RootW;

	logic                         vld_s  [N];
	logic [jcp_pkg::RemW-1:0]     rem_s  [N];
	logic [jcp_pkg::RootW-1:0]    root_s [N];
	logic [jcp_pkg::SumW-1:0]     rad_s  [N];
	jcp_pkg::jcp_side_t           side_s [N];

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic                         p_vld;
		logic [jcp_pkg::RemW-1:0]     p_rem;
		logic [jcp_pkg::RootW-1:0]    p_root;
		logic [jcp_pkg::SumW-1:0]     p_rad;
		jcp_pkg::jcp_side_t           p_side;
		logic [jcp_pkg::RemW+1:0]     sh;
		logic [jcp_pkg::RemW+1:0]     trial;
		logic [jcp_pkg::RemW-1:0]     n_rem;
		logic [jcp_pkg::RootW-1:0]    n_root;

		if (g == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_rad  = in_rad;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = vld_s[g-1];
			assign p_rem  = rem_s[g-1];
			assign p_root = root_s[g-1];
			assign p_rad  = rad_s[g-1];
			assign p_side = side_s[g-1];
		end

		always_comb begin
			sh    = {p_rem, p_rad[jcp_pkg::SumW-1 -: 2]};
			trial = {2'b00, p_root, 2'b01};
			if (sh >= trial) begin
				n_rem  = jcp_pkg::RemW'(sh - trial);
				n_root = {p_root[jcp_pkg::RootW-2:0], 1'b1};
			end else begin
				n_rem  = sh[jcp_pkg::RemW-1:0];
				n_root = {p_root[jcp_pkg::RootW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= n_rem;
				root_s[g] <= n_root;
				rad_s[g]  <= {p_rad[jcp_pkg::SumW-3:0], 2'b00};
				side_s[g] <= p_side;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_root  = root_s[N-1];
	assign out_side  = side_s[N-1];
endmodule

/* src/jcp_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on jcp_pkg.
module jcp_div (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            en,
	input  logic                                            in_valid,
	input  logic [jcp_pkg::Lanes-1:0][jcp_pkg::NumW-1:0]    in_num,
	input  logic [jcp_pkg::RootW-1:0]                       in_den,
	input  jcp_pkg::jcp_dside_t                             in_side,
	output logic                                            out_valid,
	output logic [jcp_pkg::Lanes-1:0][jcp_pkg::QuoW-1:0]    out_quo,
	output jcp_pkg::jcp_dside_t                             out_side
);
	localparam int N = jcp_pkg::QuoW;
	localparam int L = jcp_pkg::Lanes;

	logic                                     vld_s  [N];
	logic [L-1:0][jcp_pkg::RootW-1:0]         rem_s  [N];
	logic [L-1:0][jcp_pkg::QuoW-1:0]          num_s  [N];
	logic [L-1:0][jcp_pkg::QuoW-1:0]          quo_s  [N];
	logic [jcp_pkg::RootW-1:0]                den_s  [N];
	jcp_pkg::jcp_dside_t                      side_s [N];

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic                                 p_vld;
		logic [L-1:0][jcp_pkg::RootW-1:0]     p_rem;
		logic [L-1:0][jcp_pkg::QuoW-1:0]      p_num;
		logic [L-1:0][jcp_pkg::QuoW-1:0]      p_quo;
		logic [jcp_pkg::RootW-1:0]            p_den;
		jcp_pkg::jcp_dside_t                  p_side;
		logic [L-1:0][jcp_pkg::RootW-1:0]     n_rem;
		logic [L-1:0][jcp_pkg::QuoW-1:0]      n_quo;
		logic [L-1:0][jcp_pkg::QuoW-1:0]      n_num;

		if (g == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < L; i++) begin
					p_rem[i] = jcp_pkg::RootW'(in_num[i][jcp_pkg::NumW-1:jcp_pkg::QuoW]);
					p_num[i] = in_num[i][jcp_pkg::QuoW-1:0];
				end
			end
			assign p_vld  = in_valid;
			assign p_quo  = '0;
			assign p_den  = in_den;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = vld_s[g-1];
			assign p_rem  = rem_s[g-1];
			assign p_num  = num_s[g-1];
			assign p_quo  = quo_s[g-1];
			assign p_den  = den_s[g-1];
			assign p_side = side_s[g-1];
		end

		always_comb begin
			logic [jcp_pkg::RootW:0] sh;
			for (int i = 0; i < L; i++) begin
				sh = {p_rem[i], p_num[i][jcp_pkg::QuoW-1]};
				if (sh >= {1'b0, p_den}) begin
					n_rem[i] = jcp_pkg::RootW'(sh - {1'b0, p_den});
					n_quo[i] = {p_quo[i][jcp_pkg::QuoW-2:0], 1'b1};
				end else begin
					n_rem[i] = sh[jcp_pkg::RootW-1:0];
					n_quo[i] = {p_quo[i][jcp_pkg::QuoW-2:0], 1'b0};
				end
				n_num[i] = {p_num[i][jcp_pkg::QuoW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= n_rem;
				num_s[g]  <= n_num;
				quo_s[g]  <= n_quo;
				den_s[g]  <= p_den;
				side_s[g] <= p_side;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_quo   = quo_s[N-1];
	assign out_side  = side_s[N-1];
endmodule

/* src/jcp_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for joint_constraint_projection, attached by bind.
// Depends on the top level's channel interfaces.
module jcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pos_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] new_b_x,
	input logic        zero_velocity,
	input logic        distance_corrected
);
	// a held result word stays valid and keeps its x coordinate
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(new_b_x))
		else $error("result word changed while stalled");

	// fixed joint never applies the distance fix
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && zero_velocity |-> !distance_corrected)
		else $error("both flags set");

	// input stalls only while a finished word waits at the output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pos_ready |-> res_valid && !res_ready)
		else $error("input stalled without output backpressure");
endmodule

bind joint_constraint_projection jcp_checker u_jcp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.pos_ready          (pos.ready),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.new_b_x            (res.new_b_x),
	.zero_velocity      (res.zero_velocity),
	.distance_corrected (res.distance_corrected)
);

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench for joint_constraint_projection: random and corner-case body positions
// under every joint type. Checks each result word against a predictor in a scoreboard.
// Depends on jcp_pkg, the jcp_*_if interfaces and the block itself.

typedef struct packed {
	logic [2:0][31:0] a;
	logic [2:0][31:0] b;
} body_pair_t;

typedef struct packed {
	logic [2:0][31:0] nb;
	logic             zv;
	logic             dc;
} proj_word_t;

// Holds its own copy of the joint registers. Predicts each projection and keeps
// the projections that are still due on the result channel.
class proj_scoreboard;
	jcp_pkg::jcp_joint_t jtype;
	logic [30:0]         rest;
	logic signed [31:0]  off[3];
	logic signed [31:0]  axis[3];
	proj_word_t          due_q[$];
	int                  mismatches;
	int                  checked;
	int                  corrected;

	function new();
		jtype = jcp_pkg::JOINT_CIRC;
		rest = 31'd65536;
		foreach (off[i]) off[i] = 0;
		axis[0] = 0; axis[1] = 32'sd65536; axis[2] = 0;
		mismatches = 0;
		checked = 0;
		corrected = 0;
	endfunction

	function void reg_write(jcp_pkg::jcp_reg_t idx, logic [31:0] v);
		case (idx)
			jcp_pkg::REG_JOINT_TYPE: jtype = jcp_pkg::jcp_joint_t'(v[1:0]);
			jcp_pkg::REG_REST_DIST:  rest = v[30:0];
			jcp_pkg::REG_OFFSET_X:   off[0] = v;
			jcp_pkg::REG_OFFSET_Y:   off[1] = v;
			jcp_pkg::REG_OFFSET_Z:   off[2] = v;
			jcp_pkg::REG_AXIS_X:     axis[0] = v;
			jcp_pkg::REG_AXIS_Y:     axis[1] = v;
			default:                 axis[2] = v;
		endcase
	endfunction

	// Exact wide arithmetic, then one saturation per lane
	function proj_word_t project(body_pair_t p);
		logic signed [127:0] a[3], b[3], d[3], m[3], nb[3];
		logic signed [127:0] sum, len, cand, incr, mi, q;
		proj_word_t r;
		sum = 0;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			a[i] = $signed(p.a[i]);
			b[i] = $signed(p.b[i]);
			nb[i] = b[i];
		end
		if (jtype == jcp_pkg::JOINT_FIXED) begin
			for (int i = 0; i < 3; i++) nb[i] = a[i] + off[i];
			r.zv = 1'b1;
		end else if (jtype != jcp_pkg::JOINT_UNUSED) begin
			if (jtype == jcp_pkg::JOINT_HINGE)
				for (int i = 0; i < 3; i++) nb[i] = nb[i] + (axis[i] * (a[i] - b[i])) / 65536;
			for (int i = 0; i < 3; i++) begin
				d[i] = b[i] - a[i];
				m[i] = d[i] < 0 ? -d[i] : d[i];
				sum = sum + m[i] * m[i];
			end
			len = 0;
			for (int bit_i = 33; bit_i >= 0; bit_i--) begin
				cand = len | (128'sd1 <<< bit_i);
				if (cand * cand <= sum) len = cand;
			end
			incr = $signed({97'd0, rest}) - len;
			if (len != 0 && (incr > jcp_pkg::Thresh || incr < -jcp_pkg::Thresh)) begin
				mi = incr < 0 ? -incr : incr;
				for (int i = 0; i < 3; i++) begin
					q = (mi * m[i]) / len;
					nb[i] = nb[i] + (((incr < 0) != (d[i] < 0)) ? -q : q);
				end
				r.dc = 1'b1;
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (nb[i] > 128'sd2147483647) nb[i] = 128'sd2147483647;
			if (nb[i] < -128'sd2147483648) nb[i] = -128'sd2147483648;
			r.nb[i] = nb[i][31:0];
		end
		return r;
	endfunction

	function void note_input(body_pair_t p);
		due_q.push_back(project(p));
	endfunction

	function void check_result(proj_word_t got);
		proj_word_t exp_w;
		checked++;
		if (due_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result word %h", got);
			return;
		end
		exp_w = due_q.pop_front();
		if (exp_w.dc) corrected++;
		if (got !== exp_w) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp b=(%h %h %h) zv=%b dc=%b, got b=(%h %h %h) zv=%b dc=%b",
					exp_w.nb[0], exp_w.nb[1], exp_w.nb[2], exp_w.zv, exp_w.dc,
					got.nb[0], got.nb[1], got.nb[2], got.zv, got.dc);
		end
	endfunction
endclass

module tb;
	localparam int IdleLimit = 5000;  // cycles with no handshake before giving up
	localparam int Drain     = 100;   // pipeline is 75 deep

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	jcp_pos_if pos();
	jcp_cfg_if cfg();
	jcp_res_if res();

	joint_constraint_projection DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pos(pos.sink),
		.cfg(cfg.sink),
		.res(res.source)
	);

	proj_scoreboard sb = new();

	bit hold_req = 0;   // main flow asks the receiver for one long hold-off
	int sent = 0;

	always #5 clk = ~clk;

	initial begin
		pos.valid = 1'b0;
		pos.a_x = '0; pos.a_y = '0; pos.a_z = '0;
		pos.b_x = '0; pos.b_y = '0; pos.b_z = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		res.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: draws its stall pattern from four modes at random; one long hold-off on request
	initial begin
		int hold_cnt, mode, tick;
		bit held;
		hold_cnt = 0; mode = 0; tick = 0; held = 0;
		forever begin
			@(posedge clk);
			if (res.valid && res.ready)
				sb.check_result({res.new_b_z, res.new_b_y, res.new_b_x,
					res.zero_velocity, res.distance_corrected});
			tick++;
			if (tick % 64 == 0) mode = $urandom_range(0, 3);
			if (hold_req && !held) begin
				held = 1;
				hold_cnt = 300;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				res.ready <= 1'b0;
			end else begin
				case (mode)
					0: res.ready <= 1'b1;
					1: res.ready <= $urandom_range(0, 1);
					2: res.ready <= ($urandom_range(0, 3) == 0);
					default: res.ready <= ((tick % 8) < 5);
				endcase
			end
		end
	end

	// Watchdog: any cycle with a handshake on some channel resets the count
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((pos.valid && pos.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
				idle = 0;
			else
				idle++;
			if (idle >= IdleLimit) begin
				$display("timeout: %0d words still due", sb.due_q.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(jcp_pkg::jcp_reg_t idx, logic [31:0] v);
		cfg.index <= idx;
		cfg.data <= v;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.reg_write(idx, v);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Registers change only with the pipeline empty
	task automatic set_joint(jcp_pkg::jcp_joint_t jt, logic [30:0] rest_v,
			logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [31:0] xx, logic [31:0] xy, logic [31:0] xz);
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (Drain) @(posedge clk);
		write_reg(jcp_pkg::REG_JOINT_TYPE, {30'd0, jt});
		write_reg(jcp_pkg::REG_REST_DIST, {1'b0, rest_v});
		write_reg(jcp_pkg::REG_OFFSET_X, ox);
		write_reg(jcp_pkg::REG_OFFSET_Y, oy);
		write_reg(jcp_pkg::REG_OFFSET_Z, oz);
		write_reg(jcp_pkg::REG_AXIS_X, xx);
		write_reg(jcp_pkg::REG_AXIS_Y, xy);
		write_reg(jcp_pkg::REG_AXIS_Z, xz);
	endtask

	// Offer one word; valid stays high across a burst, drops for a gap
	task automatic send_pair(body_pair_t p, int gap);
		pos.a_x <= p.a[0]; pos.a_y <= p.a[1]; pos.a_z <= p.a[2];
		pos.b_x <= p.b[0]; pos.b_y <= p.b[1]; pos.b_z <= p.b[2];
		pos.valid <= 1'b1;
		@(posedge clk);
		while (!pos.ready) @(posedge clk);
		sb.note_input(p);
		sent++;
		if (gap > 0) begin
			pos.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return 32'hffffffff;
			default: return $urandom;
		endcase
	endfunction

	// Half the pairs have a distance near the rest distance; others are wide noise, extremes or small offsets
	function automatic body_pair_t random_pair();
		body_pair_t p;
		int kind, ax;
		longint len, dv;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			p.a[i] = $urandom;
			p.b[i] = $urandom;
		end
		if (kind >= 2 && kind <= 6) begin
			ax = $urandom_range(0, 2);
			len = longint'(sb.rest) + $signed($urandom_range(0, 12000)) - 6000;
			if ($urandom_range(0, 1)) len = -len;
			for (int i = 0; i < 3; i++) begin
				p.a[i] = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
				dv = (i == ax) ? len : $signed($urandom_range(0, 8000)) - 4000;
				p.b[i] = 32'(longint'($signed(p.a[i])) + dv);
			end
		end else if (kind == 7) begin
			for (int i = 0; i < 3; i++) begin
				p.a[i] = pick_extreme();
				p.b[i] = pick_extreme();
			end
		end else if (kind >= 8) begin
			for (int i = 0; i < 3; i++) begin
				p.a[i] = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
				p.b[i] = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
			end
		end
		return p;
	endfunction

	// Corners: zero distance, opposite corners, both sides of the 0.05 threshold
	task automatic directed_pairs();
		body_pair_t p;
		logic [31:0] r;
		r = {1'b0, sb.rest};
		p.a = '0; p.b = '0;
		send_pair(p, 0);
		p.a = {3{32'h12345678}}; p.b = p.a;
		send_pair(p, 1);
		p.a = {3{32'h80000000}}; p.b = {3{32'h7fffffff}};
		send_pair(p, 0);
		p.a = {3{32'h7fffffff}}; p.b = {3{32'h80000000}};
		send_pair(p, 0);
		p.a = '0; p.b = {32'd0, 32'd0, r + 32'd3277};
		send_pair(p, 0);
		p.b = {32'd0, 32'd0, r + 32'd3278};
		send_pair(p, 2);
		p.b = {32'd0, 32'd0, r - 32'd3278};
		send_pair(p, 0);
		p.b = {32'd0, -r + 32'd3277, 32'd0};
		send_pair(p, 0);
		p.b = {32'd1, 32'd0, 32'd0};
		send_pair(p, 1);
	endtask

	task automatic random_phase(int n);
		int burst, gap;
		burst = 0;
		for (int k = 0; k < n; k++) begin
			if (burst == 0) burst = $urandom_range(1, 24);
			burst--;
			gap = (burst == 0) ? $urandom_range(1, 12) : 0;
			if (k == n - 1) gap = 1;
			send_pair(random_pair(), gap);
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);

		// Reset settings: circular joint, rest 1.0
		directed_pairs();
		random_phase(80);

		set_joint(jcp_pkg::JOINT_FIXED, 31'd65536, 32'h7fffffff, 32'h80000000, $urandom,
			32'h0, 32'h0, 32'h0);
		directed_pairs();
		random_phase(80);

		// Hinge with modest axis weights; the long hold-off lands here
		set_joint(jcp_pkg::JOINT_HINGE, 31'd98304, $urandom, $urandom, $urandom,
			32'h00008000, 32'hfffe0000, 32'h00010000);
		hold_req = 1;
		random_phase(120);

		set_joint(jcp_pkg::JOINT_HINGE, 31'd0, 32'h0, 32'h0, 32'h0,
			32'h7fffffff, 32'h80000000, $urandom);
		directed_pairs();
		random_phase(80);

		set_joint(jcp_pkg::JOINT_CIRC, 31'h7fffffff, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0, 32'h0);
		directed_pairs();
		random_phase(80);

		set_joint(jcp_pkg::JOINT_UNUSED, 31'd4096, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom);
		directed_pairs();
		random_phase(40);

		set_joint(jcp_pkg::JOINT_CIRC, 31'($urandom_range(1, 1 << 20)),
			32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		directed_pairs();
		random_phase(100);

		set_joint(jcp_pkg::JOINT_FIXED, 31'd0, 32'h80000000, 32'h7fffffff, 32'h0,
			$urandom, $urandom, $urandom);
		random_phase(60);

		pos.valid <= 1'b0;
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (Drain) @(posedge clk);

		$display("sent %0d position words over fixed, hinge, circular and unused joints", sent);
		$display("checked %0d result words, %0d with distance correction", sb.checked,
			sb.corrected);
		if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d words never seen", sb.mismatches, sb.due_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
